// ----- rtl/hrs_pkg.sv -----
// Shared types and constants of the Hamming rank search unit.
package hrs_pkg;

  localparam int OP_W   = 2;
  localparam int HASH_W = 64;
  localparam int IDX_W  = 6;
  localparam int DIST_W = 7;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_RANKED = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    HOP_INC,
    HOP_DEC,
    HOP_ACC
  } hist_op_t;

  typedef struct packed {
    logic                store_we;
    logic                query_ld;
    logic                hist_clr;
    logic                hash_re;
    logic                dist_re;
    logic                prefix_req;
    logic                emit_re;
    logic                emit_last;
    logic                status_ld;
    logic [STAT_W-1:0]   status;
    logic [IDX_W-1:0]    idx;
    logic [DIST_W-1:0]   bin;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic emit_ready;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/hrs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/hrs_hist.sv -----
// Distance histogram: read-modify-write bin unit with forwarding and per-query valid bits.
module hrs_hist
  import hrs_pkg::*;
#(
  parameter int DB_DEPTH  = 64,
  parameter int HASH_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     req_vld,
  input  hist_op_t                 req_op,
  input  logic [$clog2(HASH_BITS+1)-1:0]                 req_bin,
  input  logic [((DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1)-1:0] req_idx,
  output logic                     busy,
  output logic                     place_vld,
  output logic [((DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1)-1:0] place_pos,
  output logic [((DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1)-1:0] place_idx,
  output logic [$clog2(HASH_BITS+1)-1:0]                 place_bin
);

  localparam int NB = HASH_BITS + 1;
  localparam int DW = $clog2(NB);
  localparam int IW = (DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1;
  localparam int CW = $clog2(DB_DEPTH + 1);

  logic [NB-1:0] vbit_r;
  logic          vld_a_r;
  hist_op_t      op_a_r;
  logic [DW-1:0] bin_a_r;
  logic [IW-1:0] idx_a_r;
  logic          vbit_a_r;
  logic          last_vld_r;
  logic [DW-1:0] last_bin_r;
  logic [CW-1:0] last_val_r;
  logic [CW-1:0] acc_r;
  logic [CW-1:0] ram_q;
  logic [CW-1:0] base;
  logic [CW-1:0] newv;

  hrs_ram #(
    .WIDTH (CW),
    .DEPTH (NB)
  ) u_hist_ram (
    .clk   (clk),
    .we    (vld_a_r),
    .waddr (bin_a_r),
    .wdata (newv),
    .re    (req_vld),
    .raddr (req_bin),
    .rdata (ram_q)
  );

  always_comb begin
    if (last_vld_r && (last_bin_r == bin_a_r)) begin
      base = last_val_r;
    end else if (vbit_a_r) begin
      base = ram_q;
    end else begin
      base = '0;
    end
    unique case (op_a_r)
      HOP_INC: newv = base + 1'b1;
      HOP_DEC: newv = base - 1'b1;
      HOP_ACC: newv = acc_r + base;
      default: newv = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r    <= 1'b0;
      last_vld_r <= 1'b0;
      vbit_r     <= '0;
      acc_r      <= '0;
    end else begin
      vld_a_r    <= req_vld;
      last_vld_r <= vld_a_r;
      if (clr) begin
        vbit_r <= '0;
        acc_r  <= '0;
      end else if (vld_a_r) begin
        vbit_r[bin_a_r] <= 1'b1;
        if (op_a_r == HOP_ACC) begin
          acc_r <= newv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld) begin
      op_a_r   <= req_op;
      bin_a_r  <= req_bin;
      idx_a_r  <= req_idx;
      vbit_a_r <= vbit_r[req_bin];
    end
    if (vld_a_r) begin
      last_bin_r <= bin_a_r;
      last_val_r <= newv;
    end
  end

  assign busy      = vld_a_r;
  assign place_vld = vld_a_r && (op_a_r == HOP_DEC);
  assign place_pos = newv[IW-1:0];
  assign place_idx = idx_a_r;
  assign place_bin = bin_a_r;

endmodule

// ----- rtl/hrs_datapath.sv -----
// Datapath: hash store, popcount pipeline, distance and rank buffers, result register.
module hrs_datapath
  import hrs_pkg::*;
#(
  parameter int DB_DEPTH  = 64,
  parameter int HASH_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [HASH_W-1:0]  in_hash_bits,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_db_index,
  output logic [DIST_W-1:0]  out_distance,
  output logic               out_last,
  output logic [STAT_W-1:0]  out_status
);

  localparam int NB  = HASH_BITS + 1;
  localparam int DW  = $clog2(NB);
  localparam int IW  = (DB_DEPTH > 1) ? $clog2(DB_DEPTH) : 1;
  localparam int NCH = (HASH_BITS + 7) / 8;
  localparam int RW  = IW + DW;

  logic [HASH_BITS-1:0] query_r;
  logic [HASH_BITS-1:0] hash_q;
  logic [DW-1:0]        dist_q;
  logic [RW-1:0]        rank_q;

  logic                 c1_vld_r;
  logic [IW-1:0]        c1_idx_r;
  logic                 c2_vld_r;
  logic [IW-1:0]        c2_idx_r;
  logic [3:0]           bc_r [NCH];
  logic [3:0]           bc [NCH];
  logic [NCH*8-1:0]     xv;
  logic [DW-1:0]        c2_dist;

  logic                 p1_vld_r;
  logic [IW-1:0]        p1_idx_r;

  logic                 req_vld;
  hist_op_t             req_op;
  logic [DW-1:0]        req_bin;
  logic [IW-1:0]        req_idx;
  logic                 hist_busy;
  logic                 place_vld;
  logic [IW-1:0]        place_pos;
  logic [IW-1:0]        place_idx;
  logic [DW-1:0]        place_bin;

  logic                 q_vld_r;
  logic                 q_last_r;
  logic                 q_move;
  logic                 out_take;
  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic                 out_last_r;
  logic [STAT_W-1:0]    out_stat_r;

  hrs_ram #(
    .WIDTH (HASH_BITS),
    .DEPTH (DB_DEPTH)
  ) u_hash_ram (
    .clk   (clk),
    .we    (cmd.store_we),
    .waddr (cmd.idx[IW-1:0]),
    .wdata (in_hash_bits[HASH_BITS-1:0]),
    .re    (cmd.hash_re),
    .raddr (cmd.idx[IW-1:0]),
    .rdata (hash_q)
  );

  hrs_ram #(
    .WIDTH (DW),
    .DEPTH (DB_DEPTH)
  ) u_dist_ram (
    .clk   (clk),
    .we    (c2_vld_r),
    .waddr (c2_idx_r),
    .wdata (c2_dist),
    .re    (cmd.dist_re),
    .raddr (cmd.idx[IW-1:0]),
    .rdata (dist_q)
  );

  hrs_ram #(
    .WIDTH (RW),
    .DEPTH (DB_DEPTH)
  ) u_rank_ram (
    .clk   (clk),
    .we    (place_vld),
    .waddr (place_pos),
    .wdata ({place_idx, place_bin}),
    .re    (cmd.emit_re),
    .raddr (cmd.idx[IW-1:0]),
    .rdata (rank_q)
  );

  hrs_hist #(
    .DB_DEPTH  (DB_DEPTH),
    .HASH_BITS (HASH_BITS)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cmd.hist_clr),
    .req_vld   (req_vld),
    .req_op    (req_op),
    .req_bin   (req_bin),
    .req_idx   (req_idx),
    .busy      (hist_busy),
    .place_vld (place_vld),
    .place_pos (place_pos),
    .place_idx (place_idx),
    .place_bin (place_bin)
  );

  // per-byte popcount of the XOR
  always_comb begin
    xv = (NCH*8)'(hash_q ^ query_r);
    for (int c = 0; c < NCH; c++) begin
      bc[c] = '0;
      for (int b = 0; b < 8; b++) begin
        bc[c] = bc[c] + 4'(xv[c*8+b]);
      end
    end
  end

  always_comb begin
    c2_dist = '0;
    for (int c = 0; c < NCH; c++) begin
      c2_dist = c2_dist + DW'(bc_r[c]);
    end
  end

  always_comb begin
    req_vld = 1'b0;
    req_op  = HOP_INC;
    req_bin = c2_dist;
    req_idx = c2_idx_r;
    priority if (c2_vld_r) begin
      req_vld = 1'b1;
    end else if (p1_vld_r) begin
      req_vld = 1'b1;
      req_op  = HOP_DEC;
      req_bin = dist_q;
      req_idx = p1_idx_r;
    end else if (cmd.prefix_req) begin
      req_vld = 1'b1;
      req_op  = HOP_ACC;
      req_bin = cmd.bin[DW-1:0];
    end
  end

  assign out_take = out_vld_r && !out_stall;
  assign q_move   = q_vld_r && (!out_vld_r || out_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r  <= 1'b0;
      c2_vld_r  <= 1'b0;
      p1_vld_r  <= 1'b0;
      q_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= cmd.hash_re;
      c2_vld_r <= c1_vld_r;
      p1_vld_r <= cmd.dist_re;
      if (cmd.emit_re) begin
        q_vld_r <= 1'b1;
      end else if (q_move) begin
        q_vld_r <= 1'b0;
      end
      if (q_move || cmd.status_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_ld) begin
      query_r <= in_hash_bits[HASH_BITS-1:0];
    end
    c1_idx_r <= cmd.idx[IW-1:0];
    c2_idx_r <= c1_idx_r;
    bc_r     <= bc;
    p1_idx_r <= cmd.idx[IW-1:0];
    if (cmd.emit_re) begin
      q_last_r <= cmd.emit_last;
    end
    if (q_move) begin
      out_idx_r  <= IDX_W'(rank_q[RW-1:DW]);
      out_dist_r <= DIST_W'(rank_q[DW-1:0]);
      out_last_r <= q_last_r;
      out_stat_r <= ST_RANKED;
    end else if (cmd.status_ld) begin
      out_idx_r  <= '0;
      out_dist_r <= '0;
      out_last_r <= 1'b1;
      out_stat_r <= cmd.status;
    end
  end

  assign sts.pipe_busy  = c1_vld_r || c2_vld_r || p1_vld_r || hist_busy;
  assign sts.emit_ready = !q_vld_r || q_move;
  assign sts.out_free   = !q_vld_r && (!out_vld_r || out_take);

  assign out_valid    = out_vld_r;
  assign out_db_index = out_idx_r;
  assign out_distance = out_dist_r;
  assign out_last     = out_last_r;
  assign out_status   = out_stat_r;

endmodule

// ----- rtl/hrs_ctrl.sv -----
// Controller: transaction decode, entry count and the query pass sequencer.
module hrs_ctrl
  import hrs_pkg::*;
#(
  parameter int DB_DEPTH  = 64,
  parameter int HASH_BITS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_operation,
  input  sts_t            sts,
  output cmd_t            cmd
);

  localparam int NB    = HASH_BITS + 1;
  localparam int CW    = $clog2(DB_DEPTH + 1);
  localparam int CTR_W = $clog2((DB_DEPTH > NB) ? DB_DEPTH : NB);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STATUS,
    S_COUNT,
    S_DRAIN_C,
    S_PREFIX,
    S_DRAIN_P,
    S_PLACE,
    S_DRAIN_L,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CTR_W-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [CTR_W-1:0]  last_idx;
  logic              in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign last_idx = CTR_W'(count_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    stat_nxt  = stat_r;
    cmd       = '0;
    cmd.idx   = IDX_W'(cnt_r);
    cmd.bin   = DIST_W'(cnt_r);
    cmd.status = stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_operation)
            OP_LOAD: begin
              if (count_r == CW'(DB_DEPTH)) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_STATUS;
              end else begin
                cmd.store_we = 1'b1;
                cmd.idx      = IDX_W'(count_r);
                count_nxt    = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_STATUS;
              end else begin
                cmd.query_ld = 1'b1;
                cmd.hist_clr = 1'b1;
                cnt_nxt      = '0;
                state_nxt    = S_COUNT;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.status_ld = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_COUNT: begin
        cmd.hash_re = 1'b1;
        if (cnt_r == last_idx) begin
          state_nxt = S_DRAIN_C;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN_C: begin
        if (!sts.pipe_busy) begin
          cnt_nxt   = '0;
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cmd.prefix_req = 1'b1;
        if (cnt_r == CTR_W'(HASH_BITS)) begin
          state_nxt = S_DRAIN_P;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN_P: begin
        if (!sts.pipe_busy) begin
          cnt_nxt   = last_idx;
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.dist_re = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DRAIN_L;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DRAIN_L: begin
        if (!sts.pipe_busy) begin
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.emit_ready) begin
          cmd.emit_re   = 1'b1;
          cmd.emit_last = (cnt_r == last_idx);
          if (cnt_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      count_r <= '0;
      stat_r  <= ST_RANKED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      count_r <= count_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

// ----- rtl/hamming_rank_search_unit.sv -----
// Top level of the Hamming rank search unit.
// Holds up to DB_DEPTH hashes of HASH_BITS bits, loaded in order (op 0), emptied by
// op 2. A query (op 1) computes the Hamming distance to every stored entry and
// returns one transaction per entry, nearest first, equal distances in load order,
// the final one with out_last set. A query on an empty store returns one status
// transaction (EMPTY), and a load into a full store is dropped with one status
// transaction (FULL). A query makes one pass over the store for distances and bin
// counts, one pass over the HASH_BITS+1 histogram bins for the prefix sum, one
// placement pass and one emission pass that waits out any output stall, all bound
// by the one-read, one-write histogram and buffer memories.
// The histogram is cleared per query through valid bits, so there is no clearing pass.
// The unit takes new transactions while earlier results still wait at the output.
module hamming_rank_search_unit
  import hrs_pkg::*;
#(
  parameter int DB_DEPTH  = 64,
  parameter int HASH_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [HASH_W-1:0]  in_hash_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_db_index,
  output logic [DIST_W-1:0]  out_distance,
  output logic               out_last,
  output logic [STAT_W-1:0]  out_status
);

  cmd_t cmd;
  sts_t sts;

  hrs_ctrl #(
    .DB_DEPTH  (DB_DEPTH),
    .HASH_BITS (HASH_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd)
  );

  hrs_datapath #(
    .DB_DEPTH  (DB_DEPTH),
    .HASH_BITS (HASH_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_hash_bits (in_hash_bits),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_db_index (out_db_index),
    .out_distance (out_distance),
    .out_last     (out_last),
    .out_status   (out_status)
  );

endmodule

// ----- rtl/hrs_checker.sv -----
// Port-level assertions for the Hamming rank search unit, with its bind.
module hrs_checker
  import hrs_pkg::*;
#(
  parameter int DB_DEPTH  = 64,
  parameter int HASH_BITS = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [OP_W-1:0]   in_operation,
  input logic              out_valid,
  input logic              out_stall,
  input logic [IDX_W-1:0]  out_db_index,
  input logic [DIST_W-1:0] out_distance,
  input logic              out_last,
  input logic [STAT_W-1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_db_index) &&
      $stable(out_distance) && $stable(out_last) && $stable(out_status))
    else $error("stalled result transaction changed");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_RANKED) |->
      out_last && (out_db_index == '0) && (out_distance == '0))
    else $error("status transaction not a lone zero result");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANKED) |->
      (out_distance <= HASH_BITS) && (out_db_index < DB_DEPTH))
    else $error("ranked result out of range");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_QUERY) |=> in_stall)
    else $error("query accepted without going busy");

endmodule

bind hamming_rank_search_unit hrs_checker #(
  .DB_DEPTH  (DB_DEPTH),
  .HASH_BITS (HASH_BITS)
) u_hrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_db_index (out_db_index),
  .out_distance (out_distance),
  .out_last     (out_last),
  .out_status   (out_status)
);
